>>> design/qrti_pkg.sv
// Package: shared types and constants for the binary128 round-to-integral unit
package qrti_pkg;

  localparam logic [14:0] ExpMax = 15'h7FFF;
  localparam logic [14:0] ExpBias = 15'd16383;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OnePosHi = 64'h3FFF_0000_0000_0000;
  localparam logic [63:0] OneNegHi = 64'hBFFF_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_FLOOR = 2'd0,
    KIND_CEIL  = 2'd1,
    KIND_LROUND = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [63:0] operand_hi;
    logic [63:0] operand_lo;
    logic [1:0]  kind;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        result_hi;
    logic [63:0]        result_lo;
    logic signed [63:0] int_result;
    logic               invalid;
  } out_item_t;

endpackage

>>> design/quad_round_to_integral_unit.sv
// Top level: binary128 floor / ceil / round-half-away-to-int64 unit
//
//  channel | direction | payload              | handshake
//  in_     | input     | qrti_pkg::in_item_t  | in_valid / in_stall
//  out_    | output    | qrti_pkg::out_item_t | out_valid / out_stall
//
// Input register, then the rounding logic into the result register.
// One transfer per cycle sustained while out_stall is low; the input register refills
// while the result register drains, so throughput is set only by the result register.
// Synchronous active-low reset clears both valid flags.
// in_stall is high only when both stages hold data and out_stall is high.
module quad_round_to_integral_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qrti_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qrti_pkg::out_item_t out_data
);

  logic                s1_valid_r;
  qrti_pkg::in_item_t  s1_r;
  logic                out_valid_r;
  qrti_pkg::out_item_t out_r;
  qrti_pkg::out_item_t res;
  logic                adv_out;
  logic                adv_s1;

  assign adv_out  = s1_valid_r && (!out_valid_r || !out_stall);
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1 && in_valid) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // rounding datapath
  logic          neg;
  logic [14:0]   e;
  logic [47:0]   fh;
  logic [63:0]   hi;
  logic [63:0]   lo;
  logic          is_max;
  logic          is_zero;
  logic          tiny;
  logic          big;
  logic [6:0]    f;
  logic [111:0]  mask;
  logic [111:0]  frac;
  logic [111:0]  trunc;
  logic [126:0]  body;
  logic [126:0]  sum;
  logic          away;
  logic [63:0]   fc_hi;
  logic [63:0]   fc_lo;
  logic [112:0]  sig;
  logic [6:0]    s;
  logic [112:0]  shf;
  logic [112:0]  rsh;
  logic [63:0]   ip;
  logic          rb;
  logic          ovf;
  logic [63:0]   mag;
  logic [63:0]   iv;
  logic          inv;

  always_comb begin
    hi      = s1_r.operand_hi;
    lo      = s1_r.operand_lo;
    neg     = hi[63];
    e       = hi[62:48];
    fh      = hi[47:0];
    is_max  = (e == qrti_pkg::ExpMax);
    is_zero = (e == '0) && (fh == '0) && (lo == '0);
    tiny    = (e < qrti_pkg::ExpBias);
    big     = (e >= 15'(qrti_pkg::ExpBias + 15'd112));
    f       = 7'(15'(qrti_pkg::ExpBias + 15'd112) - e);
    mask    = ~({112{1'b1}} << f);
    frac    = {hi[47:0], lo};
    trunc   = frac & ~mask;
    away    = neg ^ (s1_r.kind == qrti_pkg::KIND_CEIL);
    // add one unit at bit f to {exp, frac}; carry into exponent is natural
    body    = {hi[62:48], trunc};
    sum     = body + (away ? (127'd1 << f) : 127'd0);
    fc_hi   = hi;
    fc_lo   = lo;
    if (!(is_max || big || is_zero)) begin
      if (tiny) begin
        fc_lo = '0;
        fc_hi = away ? (neg ? qrti_pkg::OneNegHi : qrti_pkg::OnePosHi)
                     : (neg ? qrti_pkg::SignBit : 64'd0);
      end else if ((frac & mask) != '0) begin
        fc_hi = {neg, sum[126:64]};
        fc_lo = sum[63:0];
      end
    end

    sig = {1'b1, fh, lo};
    s   = 7'(15'(qrti_pkg::ExpBias + 15'd112) - e);
    shf = sig >> s;
    rsh = sig >> (s - 7'd1);
    ip  = shf[63:0];
    rb  = (s == 7'd0) ? 1'b0 : rsh[0];
    ovf = (e >= 15'(qrti_pkg::ExpBias + 15'd64));
    mag = '0;
    if (!ovf) begin
      if (rb && ip == '1) ovf = 1'b1;
      else mag = ip + 64'(rb);
    end
    iv  = '0;
    inv = 1'b0;
    if (is_max) begin
      inv = 1'b1;
      iv  = ((fh != '0) || (lo != '0) || neg) ? qrti_pkg::SignBit
                                             : ~qrti_pkg::SignBit;
    end else if (e >= 15'(qrti_pkg::ExpBias - 15'd1)) begin
      if (neg) begin
        if (ovf || mag > qrti_pkg::SignBit) begin
          iv = qrti_pkg::SignBit; inv = 1'b1;
        end else iv = 64'd0 - mag;
      end else begin
        if (ovf || mag > ~qrti_pkg::SignBit) begin
          iv = ~qrti_pkg::SignBit; inv = 1'b1;
        end else iv = mag;
      end
    end

    res = '0;
    case (qrti_pkg::kind_t'(s1_r.kind))
      qrti_pkg::KIND_FLOOR, qrti_pkg::KIND_CEIL: begin
        res.result_hi = fc_hi;
        res.result_lo = fc_lo;
      end
      qrti_pkg::KIND_LROUND: begin
        res.int_result = iv;
        res.invalid    = inv;
      end
      default: res = '0;
    endcase
  end

endmodule

>>> design/qrti_checker.sv
// Checker: port-level assertions for the round-to-integral unit, with bind
module qrti_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input qrti_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input qrti_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

  a_inv_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.result_hi == '0 && out_data.result_lo == '0)
    else $error("invalid with float result");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("transfer lost");

endmodule

bind quad_round_to_integral_unit qrti_checker u_qrti_checker (.*);

>>> test/quad_round_to_integral_unit_tb.sv
// Testbench for quad_round_to_integral_unit: random and directed operands checked against a predictor
`timescale 1ns / 1ps
module quad_round_to_integral_unit_tb;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  qrti_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  qrti_pkg::out_item_t out_data;

  quad_round_to_integral_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  qrti_pkg::in_item_t  pending_ops[$];
  qrti_pkg::out_item_t expected_results[$];
  int  mismatches = 0;
  int  transfers_in = 0;
  int  transfers_out = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  sender_hold = 1'b0;
  bit  in_taken = 1'b0;
  int  long_hold = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic qrti_pkg::out_item_t round_to_integral(qrti_pkg::in_item_t it);
    qrti_pkg::out_item_t r;
    logic        neg;
    logic [14:0] e;
    int          ex, f, s;
    logic [63:0] mh, ml, sh, ip, rb, mag;
    logic [127:0] sig, rnd;
    logic        away, ovf;
    r = '0;
    neg = it.operand_hi[63];
    e = it.operand_hi[62:48];
    ex = int'(e) - 16383;
    if (it.kind == qrti_pkg::KIND_FLOOR || it.kind == qrti_pkg::KIND_CEIL) begin
      r.result_hi = it.operand_hi;
      r.result_lo = it.operand_lo;
      away = neg ? (it.kind == qrti_pkg::KIND_FLOOR) : (it.kind == qrti_pkg::KIND_CEIL);
      if (e == qrti_pkg::ExpMax || ex >= 112) return r;
      if (e == 0 && it.operand_hi[47:0] == 0 && it.operand_lo == 0) return r;
      if (ex < 0) begin
        r.result_lo = '0;
        if (away) r.result_hi = neg ? qrti_pkg::OneNegHi : qrti_pkg::OnePosHi;
        else r.result_hi = neg ? qrti_pkg::SignBit : 64'd0;
        return r;
      end
      f = 112 - ex;
      rnd = (128'd1 << f) - 1;
      mh = rnd[127:64];
      ml = rnd[63:0];
      if ((it.operand_hi & mh) == 0 && (it.operand_lo & ml) == 0) return r;
      sig = {it.operand_hi & ~mh, it.operand_lo & ~ml};
      if (away) sig = sig + (128'd1 << f);
      {r.result_hi, r.result_lo} = sig;
    end else if (it.kind == qrti_pkg::KIND_LROUND) begin
      if (e == qrti_pkg::ExpMax) begin
        r.invalid = 1'b1;
        if (it.operand_hi[47:0] != 0 || it.operand_lo != 0) r.int_result = qrti_pkg::SignBit;
        else r.int_result = neg ? qrti_pkg::SignBit : qrti_pkg::SignBit - 1;
        return r;
      end
      if (ex < -1) return r;
      ovf = ex >= 64;
      mag = '0;
      if (!ovf) begin
        sh = {15'd0, 1'b1, it.operand_hi[47:0]};
        sig = {sh, it.operand_lo};
        s = 112 - ex;
        ip = (s >= 113) ? 64'd0 : 64'(sig >> s);
        rb = 64'(sig[s-1]);
        if (rb != 0 && ip == '1) ovf = 1'b1;
        else mag = ip + rb;
      end
      if (neg) begin
        if (ovf || mag > qrti_pkg::SignBit) begin
          r.int_result = qrti_pkg::SignBit;
          r.invalid = 1'b1;
        end else r.int_result = 64'd0 - mag;
      end else begin
        if (ovf || mag > qrti_pkg::SignBit - 1) begin
          r.int_result = qrti_pkg::SignBit - 1;
          r.invalid = 1'b1;
        end else r.int_result = mag;
      end
    end
    return r;
  endfunction

  function automatic qrti_pkg::in_item_t make_op(logic s, int ex, logic [47:0] fh,
                                                 logic [63:0] fl, qrti_pkg::kind_t k);
    qrti_pkg::in_item_t it;
    it.operand_hi = {s, 15'(ex + 16383), fh};
    it.operand_lo = fl;
    it.kind = k;
    return it;
  endfunction

  function automatic qrti_pkg::in_item_t random_op();
    qrti_pkg::in_item_t it;
    int       sel;
    sel = $urandom_range(0, 9);
    it.operand_hi = {$urandom, $urandom};
    it.operand_lo = {$urandom, $urandom};
    it.kind = qrti_pkg::kind_t'($urandom_range(0, 3));
    if (sel < 3)
      it.operand_hi[62:48] = 15'(16383 + $urandom_range(0, 115) - 2);
    else if (sel < 6)
      it.operand_hi[62:48] = 15'(16383 + $urandom_range(0, 66) - 2);
    else if (sel == 6)
      it.operand_hi[62:48] = $urandom_range(0, 1) ? qrti_pkg::ExpMax : 15'd0;
    else if (sel == 7) begin
      it.operand_hi[62:48] = 15'(16383 + $urandom_range(0, 64));
      if ($urandom_range(0, 1)) it.operand_lo = '0;
      if ($urandom_range(0, 1)) it.operand_hi[47:0] = '0;
    end
    if (sel < 8 && $urandom_range(0, 3) != 0)
      it.kind = qrti_pkg::kind_t'($urandom_range(0, 2));
    return it;
  endfunction

  initial begin
    qrti_pkg::kind_t k;
    for (int i = 0; i < 3; i++) begin
      k = qrti_pkg::kind_t'(i);
      pending_ops.push_back(make_op(1'b0, 0, 48'h8000_0000_0000, 64'd0, k));
      pending_ops.push_back(make_op(1'b1, -1, 48'h3333_3333_3333, 64'd1, k));
      pending_ops.push_back(make_op(1'b0, -2, 48'h0, 64'd5, k));
      pending_ops.push_back(make_op(1'b1, 112, '1, '1, k));
      pending_ops.push_back(make_op(1'b1, 63, 48'h0, 64'd0, k));
      pending_ops.push_back(make_op(1'b0, 63, '1, '1, k));
      pending_ops.push_back(make_op(1'b0, 16384, 48'h1, 64'd0, k));
      pending_ops.push_back(make_op(1'b1, 16384, 48'h0, 64'd0, k));
    end
    pending_ops.push_back(qrti_pkg::in_item_t'{64'h8000_0000_0000_0000, 64'd0,
                                               qrti_pkg::KIND_FLOOR});
    pending_ops.push_back(qrti_pkg::in_item_t'{64'h0000_0000_0000_0001, 64'd0,
                                               qrti_pkg::KIND_CEIL});
    pending_ops.push_back(qrti_pkg::in_item_t'{'1, '1, qrti_pkg::KIND_NONE});
    pending_ops.push_back(make_op(1'b0, 111, '1, '1, qrti_pkg::KIND_CEIL));
    for (int i = 0; i < 450; i++) pending_ops.push_back(random_op());
  end

  // sender pause until drained, once, mid-run
  initial begin
    wait (transfers_in == 150);
    @(negedge clk) sender_hold = 1'b1;
    wait (expected_results.size() == 0 && transfers_out == transfers_in);
    @(negedge clk) sender_hold = 1'b0;
  end

  // sender: a new item is offered only after the previous one transferred
  always @(negedge clk) begin
    if (rst_n) begin
      quiet <= transfers_in > 380;
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!sender_hold && pending_ops.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_ops.pop_front();
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 7);
        end else in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (transfers_in == 60 && long_hold == 0) long_hold <= 40;
      if (long_hold > 1) begin
        long_hold <= long_hold - 1;
        out_stall <= 1'b1;
      end else if (long_hold == 1) begin
        long_hold <= -1;
        out_stall <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    qrti_pkg::out_item_t want;
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(round_to_integral(in_data));
      transfers_in <= transfers_in + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      transfers_out <= transfers_out + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transfer: %h", out_data);
      end else begin
        want = expected_results.pop_front();
        if (want.result_hi !== out_data.result_hi || want.result_lo !== out_data.result_lo ||
            want.int_result !== out_data.int_result || want.invalid !== out_data.invalid) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp hi=%h lo=%h int=%h inv=%b got hi=%h lo=%h int=%h inv=%b",
                     want.result_hi, want.result_lo, want.int_result, want.invalid,
                     out_data.result_hi, out_data.result_lo, out_data.int_result,
                     out_data.invalid);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);
    $display("Checked %0d transfers: floor, ceil and lround over edge exponents, NaN, inf,",
             transfers_out);
    $display("zeros, unused kind, random idle bursts and a long output hold-off.");
    if (mismatches == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (cycles >= 200000);
    $display("Simulation FAILED");
    $finish;
  end
endmodule
